// ===== rtl/core/swm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int WSIZE_W  = 7;

	localparam logic [WSIZE_W-1:0] WSIZE_RST = 7'd3;

	// defaults for the top level parameters
	localparam int WINDOW_MAX_DEF  = 64;
	localparam int SAMPLE_BITS_DEF = 32;

	// cells per group in the median pick tree
	localparam int GROUP_N = 8;

	// one operation per cycle along the cell row
	typedef struct packed {
		logic clear;
		logic evict;
		logic insert;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/swm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swm_in_if;
	import swm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink (input valid, input sample, input restart, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/swm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface swm_out_if;
	import swm_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [MEDIAN_W-1:0] median_doubled;

	modport source (output valid, output median_doubled, input ready);
	modport sink (input valid, input median_doubled, output ready);

endinterface

`default_nettype wire

// ===== rtl/core/swm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/swm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
	parameter int VW = 32,
	parameter int AW = 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire swm_pkg::cell_cmd_t     cmd,
	input  wire logic signed [VW-1:0]   new_val,
	input  wire logic signed [VW-1:0]   ev_val,
	input  wire logic        [AW-1:0]   ev_age,
	input  wire logic signed [VW-1:0]   left_val,
	input  wire logic        [AW-1:0]   left_age,
	input  wire logic                   left_valid,
	input  wire logic                   left_lt,
	input  wire logic signed [VW-1:0]   right_val,
	input  wire logic        [AW-1:0]   right_age,
	input  wire logic                   right_valid,
	output logic signed [VW-1:0]        val,
	output logic        [AW-1:0]        age,
	output logic                        valid,
	output logic                        lt
);

	import swm_pkg::*;

	logic signed [VW-1:0] val_q;
	logic [AW-1:0]        age_q;
	logic                 valid_q;
	logic                 shift_left;

	// new sample goes in after any equal values
	assign lt = !valid_q || (new_val < val_q);

	// equal values sit youngest last, so the age breaks the tie
	assign shift_left = valid_q && ((val_q > ev_val) ||
		((val_q == ev_val) && (age_q <= ev_age)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.clear) begin
			valid_q <= 1'b0;
		end else if (cmd.evict && shift_left) begin
			valid_q <= right_valid;
		end else if (cmd.insert && lt) begin
			valid_q <= left_lt ? left_valid : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.evict && shift_left) begin
			val_q <= right_val;
			age_q <= right_age;
		end else if (cmd.insert) begin
			if (lt && left_lt) begin
				val_q <= left_val;
				age_q <= left_age + AW'(1);
			end else if (lt) begin
				val_q <= new_val;
				age_q <= '0;
			end else begin
				age_q <= age_q + AW'(1);
			end
		end
	end

	assign val   = val_q;
	assign age   = age_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/sliding_window_median_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// running median over the last window_size samples, result in doubled units
// sequence per transaction: for every sample evicted a history ram read and a cell row shift,
//   then the insert, then, once the window is full, the two-stage median pick
// a new transaction is taken only from idle, once the sequencer has stepped the cell row
//   through its evicts and its insert and any median has gone into the result register
// reset: window empty, window_size back to 3, pending result dropped; history ram not cleared
module sliding_window_median_core #(
	parameter int WINDOW_MAX  = swm_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = swm_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [swm_pkg::WSIZE_W-1:0]   cfg_wdata,
	swm_in_if.sink                             samples,
	swm_out_if.source                          medians
);

	import swm_pkg::*;

	localparam int VW = SAMPLE_BITS;
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int NG = (WINDOW_MAX + GROUP_N - 1) / GROUP_N;

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_EV   = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_MED1 = 3'd4;
	localparam logic [2:0] S_MED2 = 3'd5;

	logic [2:0]           state_q;
	logic [WSIZE_W-1:0]   wsize_q;
	logic [KW-1:0]        fill_q;
	logic [AW-1:0]        wp_q;
	logic signed [VW-1:0] sample_q;
	logic                 out_valid_q;
	logic signed [MEDIAN_W-1:0] out_data_q;

	logic [KW-1:0]        win_k;
	logic [KW-1:0]        fill_eff;
	logic [KW-1:0]        wp_ext;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        mid_a;
	logic [AW-1:0]        mid_b;
	logic signed [VW-1:0] ev_val;
	logic                 in_take;
	logic                 out_take;
	logic                 out_load;
	cell_cmd_t            cmd;

	// cell row, padded up to whole groups for the median pick
	logic signed [VW-1:0] cell_val [NG*GROUP_N];
	logic [AW-1:0]        cell_age [WINDOW_MAX];
	logic                 cell_valid [WINDOW_MAX];
	logic                 cell_lt [WINDOW_MAX];

	// median pick pipeline
	logic signed [VW-1:0] grp_a_s1 [NG];
	logic signed [VW-1:0] grp_b_s1 [NG];
	logic signed [VW-1:0] pick_a;
	logic signed [VW-1:0] pick_b;

	// effective window: zero acts as one, anything above the row length saturates
	always_comb begin
		if (32'(wsize_q) > WINDOW_MAX) begin
			win_k = KW'(WINDOW_MAX);
		end else if (wsize_q == '0) begin
			win_k = KW'(1);
		end else begin
			win_k = KW'(wsize_q);
		end
	end

	// the two middle positions coincide for an odd window
	assign mid_a = AW'(win_k >> 1);
	assign mid_b = AW'((win_k - KW'(1)) >> 1);

	// handshakes: a new transaction only from idle, the result register drains on its own
	assign samples.ready = (state_q == S_IDLE);
	assign in_take       = samples.valid && (state_q == S_IDLE);
	assign out_take      = out_valid_q && medians.ready;
	assign out_load      = (state_q == S_MED2) && (!out_valid_q || medians.ready);

	assign fill_eff = samples.restart ? '0 : fill_q;

	// commands broadcast along the cell row
	assign cmd.clear  = in_take && samples.restart;
	assign cmd.evict  = (state_q == S_EV);
	assign cmd.insert = (state_q == S_INS);

	// history ram is a ring in arrival order: the oldest sample sits fill places back
	assign wp_ext = KW'(wp_q);
	always_comb begin
		if (wp_ext >= fill_q) begin
			rd_addr = AW'(wp_ext - fill_q);
		end else begin
			rd_addr = AW'(wp_ext + KW'(WINDOW_MAX) - fill_q);
		end
	end

	swm_ram #(
		.WIDTH (VW),
		.DEPTH (WINDOW_MAX)
	) u_hist (
		.clk   (clk),
		.we    (cmd.insert),
		.waddr (wp_q),
		.wdata (sample_q),
		.raddr (rd_addr),
		.rdata (ev_val)
	);

	// sorted row of cells, each talking only to its two neighbours
	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		logic signed [VW-1:0] lv;
		logic signed [VW-1:0] rv;
		logic [AW-1:0]        la;
		logic [AW-1:0]        ra;
		logic                 lvd;
		logic                 llt;
		logic                 rvd;

		if (i == 0) begin : g_first
			assign lv  = '0;
			assign la  = '0;
			assign lvd = 1'b0;
			assign llt = 1'b0;
		end else begin : g_left
			assign lv  = cell_val[i-1];
			assign la  = cell_age[i-1];
			assign lvd = cell_valid[i-1];
			assign llt = cell_lt[i-1];
		end

		if (i == WINDOW_MAX - 1) begin : g_last
			assign rv  = '0;
			assign ra  = '0;
			assign rvd = 1'b0;
		end else begin : g_right
			assign rv  = cell_val[i+1];
			assign ra  = cell_age[i+1];
			assign rvd = cell_valid[i+1];
		end

		swm_cell #(
			.VW (VW),
			.AW (AW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.new_val     (sample_q),
			.ev_val      (ev_val),
			.ev_age      (AW'(fill_q - KW'(1))),
			.left_val    (lv),
			.left_age    (la),
			.left_valid  (lvd),
			.left_lt     (llt),
			.right_val   (rv),
			.right_age   (ra),
			.right_valid (rvd),
			.val         (cell_val[i]),
			.age         (cell_age[i]),
			.valid       (cell_valid[i]),
			.lt          (cell_lt[i])
		);
	end

	for (genvar p = WINDOW_MAX; p < NG * GROUP_N; p++) begin : g_pad
		assign cell_val[p] = '0;
	end

	// first pick stage: one candidate per group of cells for each middle position
	for (genvar g = 0; g < NG; g++) begin : g_grp
		logic signed [VW-1:0] acc_a;
		logic signed [VW-1:0] acc_b;

		always_comb begin
			acc_a = '0;
			acc_b = '0;
			for (int j = 0; j < GROUP_N; j++) begin
				if ((g * GROUP_N + j) < WINDOW_MAX) begin
					if (AW'(g * GROUP_N + j) == mid_a) begin
						acc_a = acc_a | cell_val[g * GROUP_N + j];
					end
					if (AW'(g * GROUP_N + j) == mid_b) begin
						acc_b = acc_b | cell_val[g * GROUP_N + j];
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (state_q == S_MED1) begin
				grp_a_s1[g] <= acc_a;
				grp_b_s1[g] <= acc_b;
			end
		end
	end

	// second pick stage: at most one group holds each middle value
	always_comb begin
		pick_a = '0;
		pick_b = '0;
		for (int g = 0; g < NG; g++) begin
			pick_a = pick_a | grp_a_s1[g];
			pick_b = pick_b | grp_b_s1[g];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wsize_q     <= WSIZE_RST;
			fill_q      <= '0;
			wp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wsize_q <= cfg_wdata;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						fill_q  <= fill_eff;
						state_q <= (fill_eff >= win_k) ? S_RD : S_INS;
					end
				end
				S_RD: begin
					// oldest sample comes out of the history ram
					state_q <= S_EV;
				end
				S_EV: begin
					fill_q  <= fill_q - KW'(1);
					state_q <= ((fill_q - KW'(1)) >= win_k) ? S_RD : S_INS;
				end
				S_INS: begin
					fill_q  <= fill_q + KW'(1);
					wp_q    <= (wp_q == AW'(WINDOW_MAX - 1)) ? '0 : wp_q + AW'(1);
					state_q <= ((fill_q + KW'(1)) == win_k) ? S_MED1 : S_IDLE;
				end
				S_MED1: begin
					state_q <= S_MED2;
				end
				S_MED2: begin
					// wait here while an older result still sits in the output register
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// sample payload and result register
	always_ff @(posedge clk) begin
		if (in_take) begin
			sample_q <= samples.sample[VW-1:0];
		end
		if (out_load) begin
			out_data_q <= MEDIAN_W'(pick_a) + MEDIAN_W'(pick_b);
		end
	end

	assign medians.valid          = out_valid_q;
	assign medians.median_doubled = out_data_q;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import swm_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;

	// receiver back-pressure styles, one chosen per stretch of cycles
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_PERIODIC,
		STALL_HEAVY
	} stall_mode_t;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// bound on the in-flight time of one transaction, with a full window evicted at once
	localparam int SETTLE_CYCLES = 3 + 2 * WINDOW_MAX_DEF + 32;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_LIMIT   = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [WSIZE_W-1:0] cfg_wdata = '0;

	swm_in_if  samples_if ();
	swm_out_if medians_if ();

	sliding_window_median_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_if),
		.medians   (medians_if)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// window model: arrival order for eviction, ascending order for the pick
	// ------------------------------------------------------------------
	sample_t            window_history[$];
	sample_t            window_sorted[$];
	logic [WSIZE_W-1:0] window_size_reg = WSIZE_RST;

	// medians still owed by the block, oldest first
	median_t pending_medians[$];
	median_t oldest_median;
	int      mismatch_count = 0;

	// sender burst state
	int burst_left = 0;
	bit gaps_on = 1'b1;

	// raised by a test, cleared by the receiver once its hold-off is over
	bit hold_medians = 1'b0;

	// zero means one, anything past the window depth saturates
	function automatic int unsigned live_window();
		if (window_size_reg == '0)
			return 1;
		if (window_size_reg > WINDOW_MAX_DEF)
			return WINDOW_MAX_DEF;
		return window_size_reg;
	endfunction

	// take one sample into the window and queue the doubled median once it is full
	function automatic void slide_window(input sample_t smp, input logic rst);
		int unsigned k;
		int          pos;
		sample_t     oldest;
		median_t     upper;
		median_t     lower;
		k = live_window();
		if (rst) begin
			window_history.delete();
			window_sorted.delete();
		end
		// a lowered window sheds several of its oldest samples here
		while (window_history.size() >= k) begin
			oldest = window_history.pop_front();
			for (int i = 0; i < window_sorted.size(); i++) begin
				if (window_sorted[i] == oldest) begin
					window_sorted.delete(i);
					break;
				end
			end
		end
		window_history.push_back(smp);
		pos = window_sorted.size();
		for (int i = 0; i < window_sorted.size(); i++) begin
			if (smp < window_sorted[i]) begin
				pos = i;
				break;
			end
		end
		window_sorted.insert(pos, smp);
		// no result until the window holds exactly k samples
		if (window_sorted.size() == k) begin
			upper = window_sorted[k / 2];
			lower = (k % 2 == 1) ? upper : window_sorted[k / 2 - 1];
			pending_medians.push_back(upper + lower);
		end
	endfunction

	// random sample: plain random, a narrow band for ties, zero and minus one, and values at or near the rails
	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				return sample_t'($urandom);
			end
			4, 5, 6: begin
				return sample_t'(int'($urandom_range(0, 6)) - 3);
			end
			7: begin
				case ($urandom_range(0, 3))
					0: return SAMPLE_MIN;
					1: return SAMPLE_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
			default: begin
				if ($urandom_range(0, 1))
					return SAMPLE_MAX - sample_t'($urandom_range(0, 3));
				return SAMPLE_MIN + sample_t'($urandom_range(0, 3));
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// sender: one input transaction, bursts with random gaps in between
	// ------------------------------------------------------------------
	task automatic offer_sample(input sample_t smp, input logic rst);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 10) : 0;
			if (gap > 0) begin
				samples_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples_if.valid   <= 1'b1;
		samples_if.sample  <= smp;
		samples_if.restart <= rst;
		do
			@(posedge clk);
		while (!samples_if.ready);
		slide_window(smp, rst);
	endtask

	// sender pause: every owed median back, then room for work that gives no result
	task automatic wait_idle();
		samples_if.valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	// window size only changes with the block idle, window contents kept
	task automatic write_window(input logic [WSIZE_W-1:0] size);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
		window_size_reg = size;
	endtask

	// ------------------------------------------------------------------
	// receiver: ready pattern of its own plus the long hold-off on request
	// ------------------------------------------------------------------
	initial begin
		stall_mode_t mode;
		int          stretch_left;
		int          phase;
		mode = STALL_NONE;
		stretch_left = 0;
		phase = 0;
		medians_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_medians) begin
				medians_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_medians = 1'b0;
			end else begin
				if (stretch_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					stretch_left = $urandom_range(16, 96);
				end
				stretch_left--;
				phase++;
				case (mode)
					STALL_NONE:     medians_if.ready <= 1'b1;
					STALL_COIN:     medians_if.ready <= 1'($urandom_range(0, 1));
					STALL_PERIODIC: medians_if.ready <= ((phase % 8) >= 3);
					default:        medians_if.ready <= ($urandom_range(0, 9) < 2);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// result check: every output transaction against the oldest owed median
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && medians_if.valid && medians_if.ready) begin
			if (pending_medians.size() == 0) begin
				$error("median_doubled: expected nothing, actual %0d", medians_if.median_doubled);
				mismatch_count++;
			end else begin
				oldest_median = pending_medians.pop_front();
				if (medians_if.median_doubled !== oldest_median) begin
					$error("median_doubled: expected %0d, actual %0d",
						oldest_median, medians_if.median_doubled);
					mismatch_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// directed tests
	// ------------------------------------------------------------------

	// reset window of three: rails, ties at the rails, filling from empty
	task automatic test_default_window();
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample('0, 1'b0);
		offer_sample('1, 1'b0);
	endtask

	// restart on a full window, then a refill before the next median
	task automatic test_restart_flag();
		offer_sample(sample_t'(7), 1'b1);
		offer_sample(sample_t'(1), 1'b0);
		offer_sample(sample_t'(2), 1'b0);
		offer_sample(sample_t'(100), 1'b1);
		offer_sample(sample_t'(50), 1'b0);
		offer_sample(sample_t'(-50), 1'b0);
	endtask

	// window size zero behaves as one: each sample doubled straight back
	task automatic test_single_sample_window();
		write_window('0);
		offer_sample(SAMPLE_MIN, 1'b1);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample('1, 1'b0);
	endtask

	// even window: sum of the two middles, rails mixed and equal values
	task automatic test_even_window();
		write_window(7'd2);
		offer_sample(SAMPLE_MIN, 1'b0);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(SAMPLE_MAX, 1'b0);
		offer_sample(sample_t'(4), 1'b0);
		offer_sample(sample_t'(4), 1'b0);
	endtask

	// raised mid-stream waits for a refill, lowered mid-stream sheds the oldest
	task automatic test_window_resize();
		write_window(7'd5);
		offer_sample(sample_t'(1), 1'b0);
		offer_sample(sample_t'(2), 1'b0);
		offer_sample(sample_t'(3), 1'b0);
		write_window(7'd2);
		offer_sample(sample_t'(10), 1'b0);
	endtask

	// ------------------------------------------------------------------
	// random tests
	// ------------------------------------------------------------------

	// long output hold-off while the sender keeps offering, so the block backs up
	task automatic test_output_hold();
		write_window(7'd4);
		hold_medians = 1'b1;
		gaps_on = 1'b0;
		burst_left = 0;
		for (int i = 0; i < 40; i++)
			offer_sample(rand_sample(), 1'b0);
		gaps_on = 1'b1;
		wait_idle();
	endtask

	// a run of window sizes, rails and saturation among them, contents carried across
	task automatic test_random_windows();
		int plan[$];
		int items;
		plan = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 15, 16, 31, 33, 63, 64, 127, 0, 65, 2, 10, 3, 50};
		repeat (3) plan.push_back($urandom_range(0, 127));
		foreach (plan[p]) begin
			write_window(WSIZE_W'(plan[p]));
			items = 48 + live_window() / 2;
			for (int i = 0; i < items; i++)
				offer_sample(rand_sample(), 1'($urandom_range(0, 39) == 0));
		end
	endtask

	// ------------------------------------------------------------------
	// end of run: drain with a bound, settle, verdict
	// ------------------------------------------------------------------
	task automatic finish_run();
		int waited;
		waited = 0;
		samples_if.valid <= 1'b0;
		while (pending_medians.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_medians.size() != 0) begin
			$error("median_doubled: expected %0d more results, actual none",
				pending_medians.size());
			mismatch_count++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("sliding_window_median_core: match");
		else
			$display("sliding_window_median_core: mismatch");
		$finish;
	endtask

	// stimulus sequence
	initial begin
		samples_if.valid   <= 1'b0;
		samples_if.sample  <= '0;
		samples_if.restart <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_restart_flag();
		test_single_sample_window();
		test_even_window();
		test_window_resize();
		test_output_hold();
		test_random_windows();
		finish_run();
	end

	// hard stop for a hung handshake
	initial begin
		#4000000;
		$display("sliding_window_median_core: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/swm_pkg.sv
rtl/core/swm_in_if.sv
rtl/core/swm_out_if.sv
rtl/core/swm_ram.sv
rtl/core/swm_cell.sv
rtl/core/sliding_window_median_core.sv
sim/tb.sv
